FILE: rtl/core/lss_pkg.sv
package lss_pkg;

  localparam int DEPTH = 1024;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int WW    = 32;
  localparam int OCW   = 11;

  typedef enum logic [1:0] {
    ACT_PUSH = 2'd0,
    ACT_POP  = 2'd1,
    ACT_SORT = 2'd2
  } act_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } stat_e;

  typedef enum logic [1:0] {
    RD_TOP = 2'd0,
    RD_I   = 2'd1,
    RD_J   = 2'd2
  } rd_sel_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SORT_RDI,
    S_SORT_LDI,
    S_SORT_RDJ,
    S_SORT_CMP,
    S_SORT_WRI,
    S_TOP_RD,
    S_TOP_LD
  } state_e;

  typedef struct packed {
    logic    accept;
    logic    init_i;
    logic    ld_a;
    logic    cmp;
    logic    wr_i;
    logic    ld_top;
    logic    emit;
    rd_sel_e rd_sel;
  } cmd_t;

  typedef struct packed {
    logic cnt_le1;
    logic j_last;
    logic i_last;
  } stat_t;

endpackage

FILE: rtl/core/lss_ctrl.sv
module lss_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [1:0]     action_i,
  input  lss_pkg::stat_t stat_i,
  output lss_pkg::cmd_t  cmd_o,
  output logic           busy_o
);

  lss_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lss_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.rd_sel  = lss_pkg::RD_TOP;
    busy_o        = (state_q != lss_pkg::S_IDLE);
    unique case (state_q)
      lss_pkg::S_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          case (lss_pkg::act_e'(action_i))
            lss_pkg::ACT_POP: begin
              if (stat_i.cnt_le1) begin
                cmd_o.emit = 1'b1;
              end else begin
                state_d = lss_pkg::S_TOP_RD;
              end
            end
            lss_pkg::ACT_SORT: begin
              if (stat_i.cnt_le1) begin
                cmd_o.emit = 1'b1;
              end else begin
                cmd_o.init_i = 1'b1;
                state_d      = lss_pkg::S_SORT_RDI;
              end
            end
            default: begin
              cmd_o.emit = 1'b1;
            end
          endcase
        end
      end
      lss_pkg::S_SORT_RDI: begin
        cmd_o.rd_sel = lss_pkg::RD_I;
        state_d      = lss_pkg::S_SORT_LDI;
      end
      lss_pkg::S_SORT_LDI: begin
        cmd_o.ld_a = 1'b1;
        state_d    = lss_pkg::S_SORT_RDJ;
      end
      lss_pkg::S_SORT_RDJ: begin
        cmd_o.rd_sel = lss_pkg::RD_J;
        state_d      = lss_pkg::S_SORT_CMP;
      end
      lss_pkg::S_SORT_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = stat_i.j_last ? lss_pkg::S_SORT_WRI : lss_pkg::S_SORT_RDJ;
      end
      lss_pkg::S_SORT_WRI: begin
        cmd_o.wr_i = 1'b1;
        state_d    = stat_i.i_last ? lss_pkg::S_TOP_RD : lss_pkg::S_SORT_RDI;
      end
      lss_pkg::S_TOP_RD: begin
        cmd_o.rd_sel = lss_pkg::RD_TOP;
        state_d      = lss_pkg::S_TOP_LD;
      end
      lss_pkg::S_TOP_LD: begin
        cmd_o.ld_top = 1'b1;
        cmd_o.emit   = 1'b1;
        state_d      = lss_pkg::S_IDLE;
      end
      default: begin
        state_d = lss_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/lss_dpath.sv
module lss_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lss_pkg::cmd_t                 cmd_i,
  input  logic [1:0]                    action_i,
  input  logic signed [lss_pkg::WW-1:0] push_value_i,
  output lss_pkg::stat_t                stat_o,
  output logic                          valid_o,
  output logic signed [lss_pkg::WW-1:0] popped_value_o,
  output logic [1:0]                    status_o,
  output logic signed [lss_pkg::WW-1:0] top_value_o,
  output logic                          is_empty_o,
  output logic [lss_pkg::OCW-1:0]       entry_count_o
);

  logic [lss_pkg::WW-1:0] mem [lss_pkg::DEPTH];

  logic [lss_pkg::CW-1:0] count_q, count_d;
  logic [lss_pkg::WW-1:0] top_q, top_d;
  logic [lss_pkg::WW-1:0] popped_q, popped_d;
  lss_pkg::stat_e         status_q, status_d;
  logic                   valid_q;
  logic [lss_pkg::AW-1:0] i_q, i_d;
  logic [lss_pkg::AW-1:0] j_q, j_d;
  logic [lss_pkg::WW-1:0] a_q, a_d;
  logic [lss_pkg::WW-1:0] rdata_q;

  logic                   we;
  logic [lss_pkg::AW-1:0] waddr;
  logic [lss_pkg::WW-1:0] wdata;
  logic [lss_pkg::AW-1:0] raddr;
  logic [lss_pkg::AW-1:0] top_addr;

  assign top_addr = lss_pkg::AW'(count_q - lss_pkg::CW'(1));

  always_comb begin
    count_d  = count_q;
    top_d    = top_q;
    popped_d = popped_q;
    status_d = status_q;
    i_d      = i_q;
    j_d      = j_q;
    a_d      = a_q;
    we       = 1'b0;
    waddr    = count_q[lss_pkg::AW-1:0];
    wdata    = push_value_i;

    if (cmd_i.accept) begin
      popped_d = '0;
      status_d = lss_pkg::ST_OK;
      case (lss_pkg::act_e'(action_i))
        lss_pkg::ACT_PUSH: begin
          if (count_q == lss_pkg::CW'(lss_pkg::DEPTH)) begin
            status_d = lss_pkg::ST_OVERFLOW;
          end else begin
            we      = 1'b1;
            count_d = count_q + lss_pkg::CW'(1);
            top_d   = push_value_i;
          end
        end
        lss_pkg::ACT_POP: begin
          if (count_q == '0) begin
            status_d = lss_pkg::ST_UNDERFLOW;
          end else begin
            popped_d = top_q;
            count_d  = count_q - lss_pkg::CW'(1);
            if (count_q == lss_pkg::CW'(1)) begin
              top_d = '0;
            end
          end
        end
        default: ;
      endcase
    end

    if (cmd_i.init_i) begin
      i_d = '0;
    end
    if (cmd_i.ld_a) begin
      a_d = rdata_q;
      j_d = i_q + lss_pkg::AW'(1);
    end
    if (cmd_i.cmp) begin
      if ($signed(a_q) > $signed(rdata_q)) begin
        we    = 1'b1;
        waddr = j_q;
        wdata = a_q;
        a_d   = rdata_q;
      end
      j_d = j_q + lss_pkg::AW'(1);
    end
    if (cmd_i.wr_i) begin
      we    = 1'b1;
      waddr = i_q;
      wdata = a_q;
      i_d   = i_q + lss_pkg::AW'(1);
    end
    if (cmd_i.ld_top) begin
      top_d = rdata_q;
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      lss_pkg::RD_I: raddr = i_q;
      lss_pkg::RD_J: raddr = j_q;
      default:       raddr = top_addr;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      top_q    <= '0;
      popped_q <= '0;
      status_q <= lss_pkg::ST_OK;
      valid_q  <= 1'b0;
    end else begin
      count_q  <= count_d;
      top_q    <= top_d;
      popped_q <= popped_d;
      status_q <= status_d;
      valid_q  <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d;
    j_q <= j_d;
    a_q <= a_d;
  end

  assign stat_o.cnt_le1 = (count_q < lss_pkg::CW'(2));
  assign stat_o.j_last  = (lss_pkg::CW'(j_q) == count_q - lss_pkg::CW'(1));
  assign stat_o.i_last  = (lss_pkg::CW'(i_q) == count_q - lss_pkg::CW'(2));

  assign valid_o        = valid_q;
  assign popped_value_o = popped_q;
  assign status_o       = status_q;
  assign top_value_o    = top_q;
  assign is_empty_o     = (count_q == '0);
  assign entry_count_o  = lss_pkg::OCW'(count_q);

endmodule

FILE: rtl/core/lifo_stack_with_sort.sv
// LIFO stack of 1024 signed 32-bit words with in-place ascending sort.
// Request channel: start_i with action_i (push, pop, sort) and push_value_i;
// an item is taken on a clock edge with start_i high and busy_o low.
// Result channel: valid_o is high for exactly one cycle per item, carrying
// popped_value_o, status_o, top_value_o, is_empty_o and entry_count_o.
// Results cannot be stalled; the receiver must take them when valid_o is high.
// Push, unused codes, an underflowing pop and a pop that empties the stack:
// result in the cycle after the accept, busy_o stays low, one item per cycle.
// Pop leaving one or more entries: the new top is read from the store while
// busy_o is high (S_TOP_RD, then S_TOP_LD); the result follows S_TOP_LD.
// Sort with n >= 2 entries: exchange sort through the one read and one write
// port of the store, each compare reading in S_SORT_RDJ and comparing in
// S_SORT_CMP; valid_o rises in the same cycle as busy_o falls. Sort of
// fewer than two entries behaves like a push for timing.
// Reset empties the stack (count 0, top 0); the store itself is not cleared.
module lifo_stack_with_sort (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    action_i,
  input  logic signed [lss_pkg::WW-1:0] push_value_i,
  output logic                          valid_o,
  output logic signed [lss_pkg::WW-1:0] popped_value_o,
  output logic [1:0]                    status_o,
  output logic signed [lss_pkg::WW-1:0] top_value_o,
  output logic                          is_empty_o,
  output logic [lss_pkg::OCW-1:0]       entry_count_o
);

  lss_pkg::cmd_t  cmd;
  lss_pkg::stat_t stat;

  lss_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .action_i (action_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  lss_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .action_i       (action_i),
    .push_value_i   (push_value_i),
    .stat_o         (stat),
    .valid_o        (valid_o),
    .popped_value_o (popped_value_o),
    .status_o       (status_o),
    .top_value_o    (top_value_o),
    .is_empty_o     (is_empty_o),
    .entry_count_o  (entry_count_o)
  );

endmodule
